>>> sv/midi_byte_stream_parser_macros.svh
// Assertion shorthands shared by the parser modules.
// Each expects clk and arst_n in scope.
`ifndef MIDI_BYTE_STREAM_PARSER_MACROS_SVH
`define MIDI_BYTE_STREAM_PARSER_MACROS_SVH

// Property checked every edge outside reset.
`define MBSP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Condition this edge implies property at the next edge.
`define MBSP_ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

>>> sv/mbsp_pkg.sv
package mbsp_pkg;

	typedef enum logic [3:0] {
		KIND_NOTE_OFF   = 4'd0,
		KIND_NOTE_ON    = 4'd1,
		KIND_POLY_TOUCH = 4'd2,
		KIND_CONTROL    = 4'd3,
		KIND_PROGRAM    = 4'd4,
		KIND_TOUCH      = 4'd5,
		KIND_BEND       = 4'd6,
		KIND_SONG_POS   = 4'd7,
		KIND_SONG_SEL   = 4'd8,
		KIND_SYS_RT     = 4'd9,
		KIND_SMPTE      = 4'd10,
		KIND_SX_BYTE    = 4'd11,
		KIND_SX_END     = 4'd12,
		KIND_SX_BAD     = 4'd13
	} mbsp_kind_t;

	localparam logic [7:0] STATUS_NONE     = 8'h00;
	localparam logic [7:0] STATUS_SX_START = 8'hF0;
	localparam logic [7:0] STATUS_MTC      = 8'hF1;
	localparam logic [7:0] STATUS_SONG_POS = 8'hF2;
	localparam logic [7:0] STATUS_SONG_SEL = 8'hF3;
	localparam logic [7:0] STATUS_UNDEF_F4 = 8'hF4;
	localparam logic [7:0] STATUS_UNDEF_F5 = 8'hF5;
	localparam logic [7:0] STATUS_TUNE_REQ = 8'hF6;
	localparam logic [7:0] STATUS_SX_END   = 8'hF7;
	localparam logic [7:0] STATUS_UNDEF_FD = 8'hFD;

	localparam logic [3:0] HI_PROGRAM = 4'hC;
	localparam logic [3:0] HI_TOUCH   = 4'hD;
	localparam logic [3:0] HI_BEND    = 4'hE;
	localparam logic [3:0] HI_SYSTEM  = 4'hF;

	typedef struct packed {
		logic [7:0] running_status;
		logic       sysex_open;
		logic [7:0] pending_status;
		logic       have_first;
		logic [6:0] first_data;
	} mbsp_state_t;

	typedef struct packed {
		mbsp_kind_t         event_kind;
		logic [3:0]         channel;
		logic [13:0]        value_one;
		logic [7:0]         value_two;
		logic signed [31:0] event_source;
		logic               last_of_run;
	} mbsp_result_t;

endpackage

>>> sv/mbsp_decode.sv
module mbsp_decode
	import mbsp_pkg::*;
(
	input  logic [7:0]         data_byte,
	input  logic signed [31:0] source_id,
	input  mbsp_state_t        cur,
	output mbsp_state_t        nxt,
	output mbsp_result_t       res0,
	output mbsp_result_t       res1,
	output logic [1:0]         res_count
);

	function automatic logic needs_two(input logic [7:0] st);
		needs_two = !(st[7:4] == HI_PROGRAM || st[7:4] == HI_TOUCH ||
			st == STATUS_MTC || st == STATUS_SONG_SEL);
	endfunction

	// Build the event that a final data byte completes.
	function automatic mbsp_result_t finish(input logic [7:0] st, input logic [6:0] a,
		input logic [6:0] b);
		mbsp_result_t r;
		logic [2:0]   idx;
		r = '0;
		idx = b[6:4];
		r.channel = st[3:0];
		priority if (st[7:4] == HI_PROGRAM) begin
			r.event_kind = KIND_PROGRAM;
			r.value_one = {7'd0, b};
		end else if (st[7:4] == HI_TOUCH) begin
			r.event_kind = KIND_TOUCH;
			r.value_one = {7'd0, b};
		end else if (st[7:4] == HI_BEND) begin
			r.event_kind = KIND_BEND;
			r.value_one = {b, a};
		end else if (st == STATUS_MTC) begin
			r.event_kind = KIND_SMPTE;
			r.value_one = {11'd0, idx};
			r.value_two = idx[0] ? {b[3:0], 4'd0} : {4'd0, b[3:0]};
		end else if (st == STATUS_SONG_POS) begin
			r.event_kind = KIND_SONG_POS;
			r.value_one = {b, a};
		end else if (st == STATUS_SONG_SEL) begin
			r.event_kind = KIND_SONG_SEL;
			r.value_one = {7'd0, b};
		end else begin
			// note off .. control: kind follows the status high nibble
			r.event_kind = mbsp_kind_t'({2'd0, st[5:4]});
			r.value_one = {7'd0, a};
			r.value_two = {1'b0, b};
		end
		finish = r;
	endfunction

	logic [7:0] eff_pending;
	logic       eff_have;

	always_comb begin
		nxt = cur;
		res0 = '0;
		res1 = '0;
		res_count = 2'd0;
		eff_pending = cur.pending_status;
		eff_have = cur.have_first;
		if (cur.pending_status == STATUS_NONE && cur.running_status != STATUS_NONE) begin
			eff_pending = cur.running_status;
			eff_have = 1'b0;
		end

		priority if (data_byte == STATUS_SX_END) begin
			res0.event_kind = KIND_SX_BYTE;
			res0.value_one = {6'd0, data_byte};
			res1.event_kind = cur.sysex_open ? KIND_SX_END : KIND_SX_BAD;
			res_count = 2'd2;
			nxt.sysex_open = 1'b0;
			nxt.running_status = STATUS_NONE;
			nxt.pending_status = STATUS_NONE;
			nxt.have_first = 1'b0;
		end else if (data_byte == STATUS_SX_START) begin
			if (cur.sysex_open) begin
				res0.event_kind = KIND_SX_BAD;
				res1.event_kind = KIND_SX_BYTE;
				res1.value_one = {6'd0, data_byte};
				res_count = 2'd2;
			end else begin
				res0.event_kind = KIND_SX_BYTE;
				res0.value_one = {6'd0, data_byte};
				res_count = 2'd1;
			end
			nxt.sysex_open = 1'b1;
			nxt.running_status = STATUS_NONE;
			nxt.pending_status = STATUS_NONE;
			nxt.have_first = 1'b0;
		end else if (cur.sysex_open) begin
			res0.event_kind = KIND_SX_BYTE;
			res0.value_one = {6'd0, data_byte};
			res_count = 2'd1;
			if (data_byte[7]) begin
				res1.event_kind = KIND_SX_BAD;
				res_count = 2'd2;
				nxt.sysex_open = 1'b0;
				nxt.running_status = STATUS_NONE;
				nxt.pending_status = STATUS_NONE;
				nxt.have_first = 1'b0;
			end
		end else if (data_byte[7]) begin
			if (data_byte[7:4] != HI_SYSTEM) begin
				nxt.running_status = data_byte;
				nxt.pending_status = data_byte;
				nxt.have_first = 1'b0;
			end else begin
				nxt.running_status = STATUS_NONE;
				priority if (data_byte == STATUS_MTC || data_byte == STATUS_SONG_POS ||
					data_byte == STATUS_SONG_SEL) begin
					nxt.pending_status = data_byte;
					nxt.have_first = 1'b0;
				end else if (data_byte == STATUS_UNDEF_F4 || data_byte == STATUS_UNDEF_F5 ||
					data_byte == STATUS_UNDEF_FD) begin
					nxt.pending_status = STATUS_NONE;
					nxt.have_first = 1'b0;
				end else begin
					if (data_byte == STATUS_TUNE_REQ) begin
						nxt.pending_status = STATUS_NONE;
						nxt.have_first = 1'b0;
					end
					res0.event_kind = KIND_SYS_RT;
					res0.channel = data_byte[3:0];
					res_count = 2'd1;
				end
			end
		end else begin
			// drop a data byte with nothing pending and no running status
			if (eff_pending != STATUS_NONE) begin
				if (!eff_have && needs_two(eff_pending)) begin
					nxt.pending_status = eff_pending;
					nxt.have_first = 1'b1;
					nxt.first_data = data_byte[6:0];
				end else begin
					res0 = finish(eff_pending, cur.first_data, data_byte[6:0]);
					res_count = 2'd1;
					nxt.pending_status = STATUS_NONE;
					nxt.have_first = 1'b0;
				end
			end
		end

		res0.event_source = source_id;
		res1.event_source = source_id;
		res0.last_of_run = (res_count == 2'd1);
		res1.last_of_run = (res_count == 2'd2);
	end

endmodule

>>> sv/mbsp_result_buf.sv
`include "midi_byte_stream_parser_macros.svh"

module mbsp_result_buf
	import mbsp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  logic [1:0]   load_count,
	input  mbsp_result_t load_res0,
	input  mbsp_result_t load_res1,
	output logic         room,
	output logic         head_valid,
	input  logic         head_ready,
	output mbsp_result_t head
);

	mbsp_result_t slot0_q;
	mbsp_result_t slot1_q;
	logic [1:0]   cnt_q;
	logic         pop;

	assign head_valid = (cnt_q != 2'd0);
	assign head = slot0_q;
	assign pop = head_valid && head_ready;
	// take a new byte's results once the last pending beat leaves
	assign room = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= load_count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= load_res0;
			slot1_q <= load_res1;
		end else if (pop && cnt_q == 2'd2) begin
			slot0_q <= slot1_q;
		end
	end

	`MBSP_ASSERT(a_cnt_range, cnt_q != 2'd3, "result count out of range")
	`MBSP_ASSERT(a_pair_last, cnt_q != 2'd2 || (!slot0_q.last_of_run && slot1_q.last_of_run), "pair without single last")
	`MBSP_ASSERT_NEXT(a_pair_drain, cnt_q == 2'd2 && pop, cnt_q == 2'd1, "pair did not drain to one")

endmodule

>>> sv/midi_byte_stream_parser.sv
// MIDI byte stream parser. Feed received MIDI bytes, one per input beat, with the
// sending endpoint's id; the block tracks running status, system exclusive and
// partly received messages, and emits channel, system common, real-time, SMPTE
// quarter-frame and exclusive events as output beats carrying that id. Each byte
// causes zero, one or two events; m_tlast marks the final event of a byte. A byte
// sits in the input register, is decoded in a single pass against the parser state
// and is written into a two-entry result register when it is consumed, and its first
// event then shows on the output. One byte is taken every cycle as long as each
// byte causes at most one event and the output keeps up; a byte causing two events
// (F7, F0 inside an exclusive, a status byte aborting an exclusive) holds the input
// while the second event drains from the result register. Reset leaves no running
// status, no open exclusive and nothing pending.
`include "midi_byte_stream_parser_macros.svh"

module midi_byte_stream_parser
	import mbsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [7:0] data_byte, [39:8] source_id
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [3:0] channel, [17:4] value_one, [25:18] value_two,
	                               // [57:26] event_source, [63:58] zero
	output logic [3:0]  m_tuser,   // [3:0] event_kind
	output logic        m_tlast    // last_of_run
);

	// input register stage
	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic signed [31:0] source_s1;

	// parser state
	mbsp_state_t state_q;
	mbsp_state_t state_nxt;

	mbsp_result_t res0;
	mbsp_result_t res1;
	logic [1:0]   res_count;
	logic         room;
	logic         consume;
	mbsp_result_t head;

	// state checks
	logic sx_clean_ok;
	logic rs_channel_ok;
	logic first_pending_ok;

	// Consume the registered byte whenever the result register can take its events;
	// refill the input register in the same cycle.
	assign consume = valid_s1 && room;
	assign s_tready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata[7:0];
			source_s1 <= s_tdata[39:8];
		end
	end

	// Advance the parser state only when the byte's events are committed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (consume) begin
			state_q <= state_nxt;
		end
	end

	mbsp_decode u_decode (
		.data_byte (byte_s1),
		.source_id (source_s1),
		.cur       (state_q),
		.nxt       (state_nxt),
		.res0      (res0),
		.res1      (res1),
		.res_count (res_count)
	);

	mbsp_result_buf u_result_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (consume),
		.load_count (res_count),
		.load_res0  (res0),
		.load_res1  (res1),
		.room       (room),
		.head_valid (m_tvalid),
		.head_ready (m_tready),
		.head       (head)
	);

	// Pack the head event onto the output beat.
	assign m_tdata = {6'd0, head.event_source, head.value_two, head.value_one, head.channel};
	assign m_tuser = head.event_kind;
	assign m_tlast = head.last_of_run;

	// An open exclusive leaves no running status and no pending message.
	assign sx_clean_ok = !state_q.sysex_open ||
		(state_q.running_status == STATUS_NONE && state_q.pending_status == STATUS_NONE);
	// Running status only ever holds a channel status.
	assign rs_channel_ok = state_q.running_status == STATUS_NONE ||
		(state_q.running_status[7] && state_q.running_status[7:4] != HI_SYSTEM);
	// A stored first data byte always belongs to a pending message.
	assign first_pending_ok = !state_q.have_first || state_q.pending_status != STATUS_NONE;

	`MBSP_ASSERT(a_sx_clean, sx_clean_ok, "exclusive open with status held")
	`MBSP_ASSERT(a_rs_channel, rs_channel_ok, "bad running status")
	`MBSP_ASSERT(a_first_pending, first_pending_ok, "first data byte with no message pending")

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import mbsp_pkg::*;

	localparam int RANDOM_ITEMS = 1750;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 16;
	localparam int REPORT_MAX   = 10;
	localparam int DIRECTED_LEN = 28;

	typedef struct packed {
		logic [7:0]         data_byte;
		logic signed [31:0] source_id;
	} midi_beat_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;     // [7:0] data_byte, [39:8] source_id
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;           // [3:0] channel, [17:4] value_one, [25:18] value_two,
	                                // [57:26] event_source, [63:58] zero
	logic [3:0]  m_tuser;           // [3:0] event_kind
	logic        m_tlast;

	midi_beat_t   byte_q[$];
	mbsp_result_t expected_events[$];

	// Parser state as predicted from the accepted byte stream.
	logic [7:0] run_status  = STATUS_NONE;
	logic       in_sysex    = 1'b0;
	logic [7:0] pend_status = STATUS_NONE;
	logic [1:0] data_seen   = 2'd0;
	logic [6:0] first_byte  = 7'd0;

	int fail_count   = 0;
	int bytes_queued = 0;
	int bytes_sent   = 0;
	int events_seen  = 0;
	int sysex_events = 0;
	int cycle_count  = 0;
	logic [15:0] kinds_seen = '0;

	logic beat_taken = 1'b0;
	int   burst_left = 0;
	int   gap_left   = 0;
	int   stall_mode = 0;
	int   mode_left  = 0;
	int   pat_phase  = 0;
	logic [6:0] stall_pat = 7'h7F;

	logic [7:0] directed_bytes [DIRECTED_LEN];

	midi_byte_stream_parser DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic mbsp_result_t make_event(input mbsp_kind_t kind, input logic [3:0] ch,
			input logic [13:0] v1, input logic [7:0] v2, input logic signed [31:0] src);
		mbsp_result_t ev;
		ev.event_kind   = kind;
		ev.channel      = ch;
		ev.value_one    = v1;
		ev.value_two    = v2;
		ev.event_source = src;
		ev.last_of_run  = 1'b0;
		return ev;
	endfunction

	function automatic logic needs_two_bytes(input logic [7:0] st);
		return !(st[7:4] == HI_PROGRAM || st[7:4] == HI_TOUCH ||
			st == STATUS_MTC || st == STATUS_SONG_SEL);
	endfunction

	// Build the event for a pending message whose last data byte is b.
	function automatic mbsp_result_t complete_message(input logic [7:0] st,
			input logic [7:0] b, input logic signed [31:0] src);
		logic [2:0] idx;
		logic [7:0] nib;
		if (st[7:4] == HI_PROGRAM)
			return make_event(KIND_PROGRAM, st[3:0], {7'd0, b[6:0]}, 8'd0, src);
		if (st[7:4] == HI_TOUCH)
			return make_event(KIND_TOUCH, st[3:0], {7'd0, b[6:0]}, 8'd0, src);
		if (st[7:4] == HI_BEND)
			return make_event(KIND_BEND, st[3:0], {b[6:0], first_byte}, 8'd0, src);
		if (st == STATUS_MTC) begin
			idx = b[6:4];
			nib = {4'd0, b[3:0]};
			// odd frame indices carry the high nibble
			if (idx[0])
				nib = nib << 4;
			return make_event(KIND_SMPTE, st[3:0], {11'd0, idx}, nib, src);
		end
		if (st == STATUS_SONG_POS)
			return make_event(KIND_SONG_POS, st[3:0], {b[6:0], first_byte}, 8'd0, src);
		if (st == STATUS_SONG_SEL)
			return make_event(KIND_SONG_SEL, st[3:0], {7'd0, b[6:0]}, 8'd0, src);
		return make_event(mbsp_kind_t'(st[7:4] - 4'h8), st[3:0], {7'd0, first_byte},
			{1'b0, b[6:0]}, src);
	endfunction

	task automatic drop_message;
		run_status  = STATUS_NONE;
		pend_status = STATUS_NONE;
		data_seen   = 2'd0;
	endtask

	// Advance the predicted state by one accepted byte and queue its events.
	task automatic parse_midi_byte(input logic [7:0] b, input logic signed [31:0] src);
		mbsp_result_t ev [2];
		int n;
		int i;
		n = 0;
		if (b == STATUS_SX_END) begin
			ev[0] = make_event(KIND_SX_BYTE, 4'd0, {6'd0, b}, 8'd0, src);
			ev[1] = make_event(in_sysex ? KIND_SX_END : KIND_SX_BAD, 4'd0, 14'd0, 8'd0, src);
			n = 2;
			in_sysex = 1'b0;
			drop_message();
		end else if (b == STATUS_SX_START) begin
			// a start inside an open exclusive closes the old one as broken
			if (in_sysex) begin
				ev[n] = make_event(KIND_SX_BAD, 4'd0, 14'd0, 8'd0, src);
				n++;
			end
			ev[n] = make_event(KIND_SX_BYTE, 4'd0, {6'd0, b}, 8'd0, src);
			n++;
			in_sysex = 1'b1;
			drop_message();
		end else if (in_sysex) begin
			ev[n] = make_event(KIND_SX_BYTE, 4'd0, {6'd0, b}, 8'd0, src);
			n++;
			if (b[7]) begin
				ev[n] = make_event(KIND_SX_BAD, 4'd0, 14'd0, 8'd0, src);
				n++;
				in_sysex = 1'b0;
				drop_message();
			end
		end else if (b[7]) begin
			if (b[7:4] != HI_SYSTEM) begin
				run_status  = b;
				pend_status = b;
				data_seen   = 2'd0;
			end else begin
				run_status = STATUS_NONE;
				if (b == STATUS_MTC || b == STATUS_SONG_POS || b == STATUS_SONG_SEL) begin
					pend_status = b;
					data_seen   = 2'd0;
				end else if (b == STATUS_UNDEF_F4 || b == STATUS_UNDEF_F5 ||
						b == STATUS_UNDEF_FD) begin
					pend_status = STATUS_NONE;
					data_seen   = 2'd0;
				end else begin
					// real-time bytes leave a partial message pending; tune request drops it
					if (b == STATUS_TUNE_REQ) begin
						pend_status = STATUS_NONE;
						data_seen   = 2'd0;
					end
					ev[n] = make_event(KIND_SYS_RT, b[3:0], 14'd0, 8'd0, src);
					n++;
				end
			end
		end else begin
			if (pend_status == STATUS_NONE && run_status != STATUS_NONE) begin
				pend_status = run_status;
				data_seen   = 2'd0;
			end
			// with nothing pending and no running status the byte is dropped
			if (pend_status != STATUS_NONE) begin
				if (data_seen == 2'd0 && needs_two_bytes(pend_status)) begin
					first_byte = b[6:0];
					data_seen  = 2'd1;
				end else begin
					ev[n] = complete_message(pend_status, b, src);
					n++;
					pend_status = STATUS_NONE;
					data_seen   = 2'd0;
				end
			end
		end
		if (n > 0)
			ev[n - 1].last_of_run = 1'b1;
		for (i = 0; i < n; i++)
			expected_events.insert(expected_events.size(), ev[i]);
	endtask

	// ---------------------------------------------------------------- stimulus

	function automatic logic signed [31:0] random_tag();
		case ($urandom_range(0, 15))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7FFF_FFFF;
			2:       return 32'sh0000_0000;
			3:       return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic signed [31:0] tag);
		midi_beat_t beat;
		beat.data_byte = b;
		beat.source_id = tag;
		byte_q.insert(byte_q.size(), beat);
		bytes_queued++;
	endtask

	// Data bytes, now and then with a system byte from F8 to FF slipped in between.
	task automatic push_data(input int count);
		int i;
		for (i = 0; i < count; i++) begin
			if ($urandom_range(0, 11) == 0)
				push_byte(8'($urandom_range(8'hF8, 8'hFF)), random_tag());
			push_byte(8'($urandom_range(0, 127)), random_tag());
		end
	endtask

	task automatic add_random_message;
		int pick;
		logic [7:0] st;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			// channel message; skip the status now and then to lean on running status
			st = 8'($urandom_range(8'h80, 8'hEF));
			if ($urandom_range(0, 3) != 0)
				push_byte(st, random_tag());
			push_data((st[7:4] == HI_PROGRAM || st[7:4] == HI_TOUCH) ? 1 : 2);
		end else if (pick < 55) begin
			st = 8'($urandom_range(STATUS_MTC, STATUS_SONG_SEL));
			push_byte(st, random_tag());
			push_data((st == STATUS_SONG_POS) ? 2 : 1);
		end else if (pick < 72) begin
			push_byte(STATUS_SX_START, random_tag());
			push_data($urandom_range(0, 8));
			case ($urandom_range(0, 9))
				0: push_byte(STATUS_SX_START, random_tag());
				1: begin
					st = 8'($urandom_range(8'h80, 8'hFF));
					if (st == STATUS_SX_START || st == STATUS_SX_END)
						st = STATUS_UNDEF_F4;
					push_byte(st, random_tag());
				end
				default: push_byte(STATUS_SX_END, random_tag());
			endcase
		end else if (pick < 82) begin
			st = 8'($urandom_range(STATUS_UNDEF_F4, 8'hFF));
			if (st == STATUS_SX_END)
				st = STATUS_TUNE_REQ;
			push_byte(st, random_tag());
		end else begin
			push_byte(8'($urandom_range(0, 255)), random_tag());
		end
	endtask

	// ---------------------------------------------------------------- sender

	always @(negedge clk) begin : drive_bytes
		midi_beat_t beat;
		// hold the current beat until it is taken
		if (!(s_tvalid && !beat_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (arst_n && byte_q.size() > 0) begin
				beat = byte_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {beat.source_id, beat.data_byte};
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	always @(negedge clk) begin : pace_receiver
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left  = $urandom_range(64, 256);
			stall_pat  = 7'($urandom) | 7'h01;
		end
		mode_left--;
		pat_phase = (pat_phase == 6) ? 0 : pat_phase + 1;
		case (stall_mode)
			0:       m_tready <= 1'b1;
			1:       m_tready <= ($urandom_range(0, 3) != 0);
			2:       m_tready <= stall_pat[pat_phase];
			default: m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// ---------------------------------------------------------------- checker

	function automatic string show_event(input mbsp_result_t ev);
		return $sformatf("kind=%0d ch=%0d v1=%0d v2=%0d src=%h last=%0d", ev.event_kind,
			ev.channel, ev.value_one, ev.value_two, ev.event_source, ev.last_of_run);
	endfunction

	task automatic log_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_MAX)
			$display("%0t ns: %s", $time, msg);
	endtask

	always @(posedge clk) begin : watch_ports
		mbsp_result_t got;
		mbsp_result_t want;
		if (!arst_n) begin
			beat_taken <= 1'b0;
		end else begin
			beat_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				parse_midi_byte(s_tdata[7:0], s_tdata[39:8]);
				bytes_sent++;
			end
			if (m_tvalid && m_tready) begin
				got.event_kind   = mbsp_kind_t'(m_tuser);
				got.channel      = m_tdata[3:0];
				got.value_one    = m_tdata[17:4];
				got.value_two    = m_tdata[25:18];
				got.event_source = m_tdata[57:26];
				got.last_of_run  = m_tlast;
				events_seen++;
				kinds_seen[m_tuser] = 1'b1;
				if (m_tuser == KIND_SX_BYTE || m_tuser == KIND_SX_END || m_tuser == KIND_SX_BAD)
					sysex_events++;
				if (expected_events.size() == 0) begin
					log_failure({"event with none expected: ", show_event(got)});
				end else begin
					want = expected_events.pop_front();
					if (got.event_kind !== want.event_kind || got.channel !== want.channel ||
							got.value_one !== want.value_one ||
							got.value_two !== want.value_two ||
							got.event_source !== want.event_source ||
							got.last_of_run !== want.last_of_run)
						log_failure({"mismatch: expected ", show_event(want),
							" got ", show_event(got)});
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d events still expected", cycle_count,
				expected_events.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin : run_test
		int i;
		logic signed [31:0] edge_tags [4];
		edge_tags = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, -32'sd1};
		// orphan data; note on; note off finished across a real-time byte; orphan again;
		// full bend; exclusive start/restart/end; stray end; abort by status;
		// odd quarter frame; song position and select; undefined system bytes
		directed_bytes = '{8'h40, 8'h90, 8'h00, 8'h7F, 8'h8F, 8'h12, 8'hFF, 8'h34, 8'h55,
			8'hEF, 8'h7F, 8'h7F, 8'hF0, 8'h7F, 8'hF0, 8'hF7, 8'hF7, 8'hF0, 8'h90,
			8'hF1, 8'h35, 8'hF2, 8'h01, 8'h7F, 8'hF3, 8'h7F, 8'hF4, 8'hFD};
		for (i = 0; i < DIRECTED_LEN; i++)
			push_byte(directed_bytes[i], edge_tags[i % 4]);
		while (bytes_queued < DIRECTED_LEN + RANDOM_ITEMS)
			add_random_message();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (byte_q.size() != 0 || s_tvalid || expected_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		for (i = 0; i < expected_events.size(); i++)
			log_failure({"never seen: ", show_event(expected_events[i])});

		$display("Fed %0d MIDI bytes and checked %0d events (%0d from exclusives),",
			bytes_sent, events_seen, sysex_events);
		$display("%0d of 14 kinds seen; failures: %0d over %0d cycles.",
			$countones(kinds_seen), fail_count, cycle_count);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
